// File: rtl/core/bprls_pkg.sv
// Shared types and constants of the BPR bisection line search.
`timescale 1ns / 1ps
`default_nettype none
package bprls_pkg;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0] HALF_Q16    = 17'h08000;
  localparam logic [23:0] RATIO_MAX   = 24'hFFFFFF;
  localparam logic [16:0] EPS_RESET   = 17'd66;
  localparam logic [3:0]  POWER_MAX   = 4'd8;
  localparam int          DIV_STEPS   = 24;

  // register byte addresses
  localparam logic [2:0]  REG_EPSILON = 3'd0;

  // step-point load selects
  localparam logic [1:0]  A_ZERO = 2'd0;
  localparam logic [1:0]  A_ONE  = 2'd1;
  localparam logic [1:0]  A_HALF = 2'd2;
  localparam logic [1:0]  A_MID  = 2'd3;

  // one stored link
  typedef struct packed {
    logic [23:0]        flow;
    logic signed [24:0] dir;
    logic [23:0]        cap;
    logic [23:0]        t0;
    logic [15:0]        coef;
    logic [3:0]         pw;
  } link_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       srch_init;
    logic       clr_sum;
    logic       flow;
    logic       fsat;
    logic       div_step;
    logic       pow_step;
    logic       gain;
    logic       cost;
    logic       mag_lo;
    logic       mag_hi;
    logic       mag_sum;
    logic       acc;
    logic       a_ld;
    logic [1:0] a_sel;
    logic       bound_upd;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       f_sat;
    logic [3:0] pw;
    logic       sum_neg;
    logic       sum_zero;
    logic       narrow;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/bpr_bisection_line_search.sv
// Top level of the BPR bisection line search: register port and unit wiring.
`timescale 1ns / 1ps
`default_nettype none
// Links are loaded one per cycle (start high while busy is low) into an
// internal link memory of NUM_LINKS entries; links past that are dropped.
// A link with last_link set ends the batch, busy rises and the search runs
// over the stored links. Each slope evaluation walks every link through a
// shared arithmetic unit: read, flow, saturation check, the bit-serial ratio
// divider (skipped when the ratio saturates), power steps as many as the
// link's BPR power, gain, cost, low and high magnitude products, their sum
// and accumulation; each evaluation also clears the sum and ends in a
// decision, and each bisection step adds a midpoint load. The search does
// one evaluation at step 0, one at step 1 and then up to 16 bisection
// evaluations. The single result appears for exactly one cycle with
// out_valid high; the receiver cannot stall it, and busy drops on the
// following cycle. epsilon is written over the register port at byte
// address 0 and must only be changed while busy is low.
module bpr_bisection_line_search
  import bprls_pkg::*;
#(
  parameter int NUM_LINKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transfer
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_current_flow,
  input  wire logic [23:0] in_target_flow,
  input  wire logic [23:0] in_capacity,
  input  wire logic [23:0] in_free_time,
  input  wire logic [15:0] in_bpr_coefficient,
  input  wire logic [3:0]  in_bpr_power,
  input  wire logic        in_last_link,
  // result transfer
  output logic             out_valid,
  output logic [16:0]      out_step_size,
  output logic [4:0]       out_bisection_steps,
  output logic             out_overflow,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  logic [16:0]   eps_r;
  cmd_t          cmd;
  sts_t          sts;
  link_t         wr_link;
  logic [AW-1:0] wr_addr, rd_addr;

  // register port: always ready, write lands in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == REG_EPSILON) ? {15'h0000, eps_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_EPSILON)) begin
      eps_r <= pwdata[16:0];
    end
  end

  // link record as stored: direction kept signed, power clamped to eight
  always_comb begin
    wr_link.flow = in_current_flow;
    wr_link.dir  = $signed({1'b0, in_target_flow}) - $signed({1'b0, in_current_flow});
    wr_link.cap  = in_capacity;
    wr_link.t0   = in_free_time;
    wr_link.coef = in_bpr_coefficient;
    wr_link.pw   = (in_bpr_power > POWER_MAX) ? POWER_MAX : in_bpr_power;
  end

  bprls_ctrl #(.NUM_LINKS(NUM_LINKS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_link (in_last_link),
    .sts       (sts),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .busy      (busy),
    .out_valid (out_valid),
    .steps     (out_bisection_steps)
  );

  bprls_datapath #(.NUM_LINKS(NUM_LINKS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_link   (wr_link),
    .eps       (eps_r),
    .sts       (sts),
    .step_size (out_step_size),
    .overflow  (out_overflow)
  );

endmodule
`default_nettype wire

// File: rtl/core/bprls_datapath.sv
// Datapath: link memory, per-link cost arithmetic, slope accumulator, bounds.
`timescale 1ns / 1ps
`default_nettype none
module bprls_datapath
  import bprls_pkg::*;
#(
  parameter int NUM_LINKS = 1024,
  localparam int AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] rd_addr,
  input  wire link_t         wr_link,
  input  wire logic [16:0]   eps,
  output sts_t               sts,
  output logic [16:0]        step_size,
  output logic               overflow
);

  link_t mem [NUM_LINKS];
  link_t rdat_r;

  logic signed [42:0] prod_r;
  logic [23:0]        rem_r, q_r, p_r;
  logic [26:0]        g_r;
  logic [34:0]        cost_r;
  logic [41:0]        lo_r;
  logic [40:0]        hi_r;
  logic [58:0]        mag_r;
  logic signed [63:0] sum_r;
  logic               ovf_r;
  logic [16:0]        a_r, lob_r, hib_r;

  // combinational helpers
  logic signed [25:0] fsum;
  logic [23:0]        f;
  logic               f_sat;
  logic [24:0]        dsh;
  logic               dge;
  logic [24:0]        dsub;
  logic [47:0]        pp;
  logic [39:0]        ap;
  logic [50:0]        tg;
  logic [24:0]        ad_full;
  logic [23:0]        ad;
  logic signed [64:0] term, s65;
  logic [17:0]        mid;
  logic [16:0]        eps_eff;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_link;
    end
    if (cmd.rd) begin
      rdat_r <= mem[rd_addr];
    end
  end

  always_comb begin
    fsum    = $signed({2'b00, rdat_r.flow}) + $signed(prod_r[41:16]);
    f       = fsum[23:0];
    f_sat   = {8'h00, f} >= {rdat_r.cap, 8'h00};
    dsh     = {rem_r, q_r[23]};
    dge     = dsh >= {1'b0, rdat_r.cap};
    dsub    = dsh - {1'b0, rdat_r.cap};
    pp      = p_r * q_r;
    ap      = rdat_r.coef * p_r;
    tg      = rdat_r.t0 * g_r;
    ad_full = rdat_r.dir[24] ? 25'(-rdat_r.dir) : rdat_r.dir;
    ad      = ad_full[23:0];
    term    = rdat_r.dir[24] ? -$signed({6'b0, mag_r}) : $signed({6'b0, mag_r});
    s65     = $signed({sum_r[63], sum_r}) + term;
    mid     = ({1'b0, lob_r} + {1'b0, hib_r}) >> 1;
    eps_eff = (eps == 17'd0) ? 17'd1 : eps;
  end

  always_ff @(posedge clk) begin
    if (cmd.flow) begin
      // floor(d * a / 2^16) taken from bit 16 up; x is added in the next step
      prod_r <= 43'($signed(rdat_r.dir) * $signed({1'b0, a_r}));
      p_r    <= {7'h00, ONE_Q16};
    end
    if (cmd.fsat) begin
      if (f_sat) begin
        q_r <= RATIO_MAX;
      end else begin
        rem_r <= {8'h00, f[23:8]};
        q_r   <= {f[7:0], 16'h0000};
      end
    end
    if (cmd.div_step) begin
      rem_r <= dge ? dsub[23:0] : dsh[23:0];
      q_r   <= {q_r[22:0], dge};
    end
    if (cmd.pow_step) begin
      p_r <= (|pp[47:40]) ? RATIO_MAX : pp[39:16];
    end
    if (cmd.gain) begin
      g_r <= {1'b0, ap[39:14]} + {10'h000, ONE_Q16};
    end
    if (cmd.cost) begin
      cost_r <= tg[50:16];
    end
    if (cmd.mag_lo) begin
      lo_r <= cost_r[17:0] * ad;
    end
    if (cmd.mag_hi) begin
      hi_r <= cost_r[34:18] * ad;
    end
    if (cmd.mag_sum) begin
      mag_r <= {17'h00000, lo_r} + {hi_r, 18'h00000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
      a_r   <= '0;
      lob_r <= '0;
      hib_r <= ONE_Q16;
    end else begin
      if (cmd.srch_init) begin
        ovf_r <= 1'b0;
        lob_r <= '0;
        hib_r <= ONE_Q16;
      end
      if (cmd.clr_sum) begin
        sum_r <= '0;
      end
      if (cmd.fsat && f_sat) begin
        ovf_r <= 1'b1;
      end
      if (cmd.pow_step && (|pp[47:40])) begin
        ovf_r <= 1'b1;
      end
      if (cmd.acc) begin
        if (s65[64] != s65[63]) begin
          sum_r <= s65[64] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
          ovf_r <= 1'b1;
        end else begin
          sum_r <= s65[63:0];
        end
      end
      if (cmd.a_ld) begin
        unique case (cmd.a_sel)
          A_ZERO:  a_r <= '0;
          A_ONE:   a_r <= ONE_Q16;
          A_HALF:  a_r <= HALF_Q16;
          A_MID:   a_r <= mid[16:0];
          default: a_r <= '0;
        endcase
      end
      if (cmd.bound_upd) begin
        if (sum_r <= 0) begin
          lob_r <= a_r;
        end else begin
          hib_r <= a_r;
        end
      end
    end
  end

  always_comb begin
    sts.f_sat    = f_sat;
    sts.pw       = rdat_r.pw;
    sts.sum_neg  = sum_r[63];
    sts.sum_zero = (sum_r == 64'sd0);
    sts.narrow   = (hib_r - lob_r) <= eps_eff;
  end

  assign step_size = a_r;
  assign overflow  = ovf_r;

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    lob_r < hib_r) else $error("bisection bounds crossed");
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_r <= ONE_Q16) else $error("step point above one");

endmodule
`default_nettype wire

// File: rtl/core/bprls_ctrl.sv
// Controller: load sequencing, per-link micro-steps and bisection decisions.
`timescale 1ns / 1ps
`default_nettype none
module bprls_ctrl
  import bprls_pkg::*;
#(
  parameter int NUM_LINKS = 1024,
  localparam int AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1,
  localparam int CW = $clog2(NUM_LINKS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          last_link,
  input  wire sts_t          sts,
  output cmd_t               cmd,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  output logic               busy,
  output logic               out_valid,
  output logic [4:0]         steps
);

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_EVAL   = 5'd2;
  localparam logic [4:0] S_RD     = 5'd3;
  localparam logic [4:0] S_FLOW   = 5'd4;
  localparam logic [4:0] S_FSAT   = 5'd5;
  localparam logic [4:0] S_DIV    = 5'd6;
  localparam logic [4:0] S_POW    = 5'd7;
  localparam logic [4:0] S_GAIN   = 5'd8;
  localparam logic [4:0] S_COST   = 5'd9;
  localparam logic [4:0] S_MLO    = 5'd10;
  localparam logic [4:0] S_MHI    = 5'd11;
  localparam logic [4:0] S_MSUM   = 5'd12;
  localparam logic [4:0] S_ACC    = 5'd13;
  localparam logic [4:0] S_DECIDE = 5'd14;
  localparam logic [4:0] S_NEXT   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  localparam logic [1:0] M_ZERO = 2'd0;
  localparam logic [1:0] M_ONE  = 2'd1;
  localparam logic [1:0] M_BIS  = 2'd2;

  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  logic [4:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [4:0]    steps_r, steps_nxt;
  logic          accept;

  assign accept = start && (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (count_r < CW'(NUM_LINKS)) begin
            cmd.wr    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (last_link) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.srch_init = 1'b1;
        cmd.a_ld      = 1'b1;
        cmd.a_sel     = A_ZERO;
        mode_nxt      = M_ZERO;
        steps_nxt     = '0;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        cmd.clr_sum = 1'b1;
        idx_nxt     = '0;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FLOW;
      end
      S_FLOW: begin
        cmd.flow  = 1'b1;
        state_nxt = S_FSAT;
      end
      S_FSAT: begin
        cmd.fsat  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.f_sat ? S_POW : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_POW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_POW: begin
        if (cnt_r == {1'b0, sts.pw}) begin
          state_nxt = S_GAIN;
        end else begin
          cmd.pow_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_COST;
      end
      S_COST: begin
        cmd.cost  = 1'b1;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mag_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mag_hi = 1'b1;
        state_nxt  = S_MSUM;
      end
      S_MSUM: begin
        cmd.mag_sum = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (idx_r == count_r - 1'b1) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DECIDE: begin
        unique case (mode_r)
          M_ZERO: begin
            if (!sts.sum_neg) begin
              state_nxt = S_DONE;
            end else begin
              cmd.a_ld  = 1'b1;
              cmd.a_sel = A_ONE;
              mode_nxt  = M_ONE;
              state_nxt = S_EVAL;
            end
          end
          M_ONE: begin
            if (sts.sum_neg || sts.sum_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.a_ld  = 1'b1;
              cmd.a_sel = A_HALF;
              mode_nxt  = M_BIS;
              state_nxt = S_EVAL;
            end
          end
          default: begin
            cmd.bound_upd = 1'b1;
            steps_nxt     = steps_r + 1'b1;
            state_nxt     = S_NEXT;
          end
        endcase
      end
      S_NEXT: begin
        cmd.a_ld  = 1'b1;
        cmd.a_sel = A_MID;
        state_nxt = sts.narrow ? S_DONE : S_EVAL;
      end
      S_DONE: begin
        count_nxt = '0;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      mode_r  <= M_ZERO;
      count_r <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      steps_r <= steps_nxt;
    end
  end

  assign wr_addr   = count_r[AW-1:0];
  assign rd_addr   = idx_r[AW-1:0];
  assign busy      = (state_r != S_LOAD);
  assign out_valid = (state_r == S_DONE);
  assign steps     = steps_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !last_link) |=> !busy) else $error("left load on non-final link");

endmodule
`default_nettype wire
